// ===== rtl/ffea_pkg.sv =====
// Package for the first-fit extent allocator.
// Holds command, status and config index codes and widths; no dependencies.
`default_nettype none
package ffea_pkg;
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_INIT  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFIT  = 2'd1;
  localparam logic [1:0] ST_ZERO   = 2'd2;
  localparam logic [1:0] ST_LOST   = 2'd3;

  localparam logic CFG_REGION_BASE = 1'b0;
  localparam logic CFG_REGION_SIZE = 1'b1;

  localparam int CNT_W = 11;
  localparam int DATA_W = 32;
endpackage
`default_nettype wire

// ===== rtl/first_fit_extent_allocator_core.sv =====
// Top level of the first-fit extent allocator with coalescing.
// Uses ffea_pkg; holds the extent table memory and its sequencer.
//
// Each transaction is handled one at a time. Alloc scans the table one entry
// per cycle until a fit, then moves later entries down one per cycle if the
// extent empties. Free scans to its sorted place, then either merges, moves
// entries up one per cycle to insert, moves down after a double merge, or
// counts the block lost when the table is full. Init, no-op and zero-size
// alloc go straight to the result state; any result waits out an output stall.
// All cost is set by the single-port read, single-port write extent memory.
`default_nettype none
module first_fit_extent_allocator_core #(
  parameter int TABLE_DEPTH = 1024,
  parameter int ADDR_WIDTH  = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_cmd,
  input  wire logic [ADDR_WIDTH-1:0] in_block_addr,
  input  wire logic [ADDR_WIDTH-1:0] in_block_size,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 out_status,
  output logic [ADDR_WIDTH-1:0]      out_alloc_base,
  output logic [ffea_pkg::CNT_W-1:0] out_extent_count,
  output logic [31:0]                out_lost_blocks,
  output logic [31:0]                out_lost_bytes,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic                  cfg_index,
  input  wire logic [31:0]           cfg_data
);
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = ADDR_WIDTH;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_ASCAN = 4'd2;
  localparam logic [3:0] S_DOWN  = 4'd6;
  localparam logic [3:0] S_UP    = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  typedef struct packed {
    logic [AW-1:0] start;
    logic [AW-1:0] len;
  } ext_t;

  ext_t mem [TABLE_DEPTH];
  ext_t rd_q;
  logic [IW-1:0] rd_addr;
  logic rd_en;
  logic wr_en;
  logic [IW-1:0] wr_addr;
  ext_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  logic [3:0] state_r, state_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic [31:0] lblk_r, lblk_nxt, lbyt_r, lbyt_nxt;
  logic [31:0] rbase_r, rsize_r;
  logic [1:0] cmd_r, cmd_nxt;
  logic [AW-1:0] addr_r, addr_nxt, size_r, size_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  ext_t prev_r, prev_nxt;
  logic [1:0] stat_r, stat_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic ov_r, ov_nxt;
  logic [1:0] o_stat_r;
  logic [AW-1:0] o_base_r;
  logic [ffea_pkg::CNT_W-1:0] o_cnt_r;
  logic [31:0] o_lblk_r, o_lbyt_r;

  logic [32:0] sum_bytes;
  logic prev_touch;
  logic [CW-1:0] pos_m1;
  assign sum_bytes = {1'b0, lbyt_r} + 33'(size_r);
  assign prev_touch = (pos_r != '0) && ((prev_r.start + prev_r.len) == addr_r);
  assign pos_m1 = pos_r - 1'b1;

  assign in_ready = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    total_nxt = total_r;
    lblk_nxt = lblk_r;
    lbyt_nxt = lbyt_r;
    cmd_nxt = cmd_r;
    addr_nxt = addr_r;
    size_nxt = size_r;
    pos_nxt = pos_r;
    prev_nxt = prev_r;
    stat_nxt = stat_r;
    base_nxt = base_r;
    ov_nxt = ov_r;
    rd_en = 1'b0;
    rd_addr = pos_r[IW-1:0];
    wr_en = 1'b0;
    wr_addr = pos_r[IW-1:0];
    wr_data = rd_q;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_cmd;
          addr_nxt = in_block_addr;
          size_nxt = in_block_size;
          stat_nxt = ffea_pkg::ST_OK;
          base_nxt = '0;
          pos_nxt = '0;
          rd_en = 1'b1;
          rd_addr = '0;
          state_nxt = S_DONE;
          case (in_cmd)
            ffea_pkg::CMD_ALLOC: begin
              if (in_block_size == '0) stat_nxt = ffea_pkg::ST_ZERO;
              else state_nxt = S_ASCAN;
            end
            ffea_pkg::CMD_FREE: state_nxt = S_SCAN;
            ffea_pkg::CMD_INIT: begin
              lblk_nxt = '0;
              lbyt_nxt = '0;
              total_nxt = '0;
              if (rsize_r != '0) begin
                wr_en = 1'b1;
                wr_addr = '0;
                wr_data.start = AW'(rbase_r);
                wr_data.len = AW'(rsize_r);
                total_nxt = CW'(1);
              end
            end
            default: ;
          endcase
        end
      end
      S_ASCAN: begin
        if (pos_r >= total_r) begin
          stat_nxt = ffea_pkg::ST_NOFIT;
          state_nxt = S_DONE;
        end else if (rd_q.len >= size_r) begin
          base_nxt = rd_q.start;
          if (rd_q.len == size_r) begin
            state_nxt = S_DOWN;
            rd_en = 1'b1;
            rd_addr = IW'(pos_r + 1'b1);
          end else begin
            wr_en = 1'b1;
            wr_data.start = rd_q.start + size_r;
            wr_data.len = rd_q.len - size_r;
            state_nxt = S_DONE;
          end
        end else begin
          pos_nxt = pos_r + 1'b1;
          rd_en = 1'b1;
          rd_addr = IW'(pos_r + 1'b1);
        end
      end
      S_DOWN: begin
        if (pos_r + 1'b1 >= total_r) begin
          total_nxt = total_r - 1'b1;
          state_nxt = S_DONE;
        end else begin
          wr_en = 1'b1;
          wr_data = rd_q;
          pos_nxt = pos_r + 1'b1;
          rd_en = 1'b1;
          rd_addr = IW'(pos_r + 2'd2);
        end
      end
      S_SCAN: begin
        if (pos_r < total_r && !(rd_q.start > addr_r)) begin
          prev_nxt = rd_q;
          pos_nxt = pos_r + 1'b1;
          rd_en = 1'b1;
          rd_addr = IW'(pos_r + 1'b1);
        end else begin
          if (prev_touch) begin
            if (pos_r < total_r && (addr_r + size_r) == rd_q.start) begin
              wr_en = 1'b1;
              wr_addr = pos_m1[IW-1:0];
              wr_data.start = prev_r.start;
              wr_data.len = prev_r.len + size_r + rd_q.len;
              rd_en = 1'b1;
              rd_addr = IW'(pos_r + 1'b1);
              state_nxt = S_DOWN;
            end else begin
              wr_en = 1'b1;
              wr_addr = pos_m1[IW-1:0];
              wr_data.start = prev_r.start;
              wr_data.len = prev_r.len + size_r;
              state_nxt = S_DONE;
            end
          end else if (pos_r < total_r && (addr_r + size_r) == rd_q.start) begin
            wr_en = 1'b1;
            wr_data.start = addr_r;
            wr_data.len = rd_q.len + size_r;
            state_nxt = S_DONE;
          end else if (total_r < DEPTH_C) begin
            pos_nxt = total_r;
            prev_nxt.start = '0;
            prev_nxt.len = AW'(pos_r);
            state_nxt = S_UP;
            if (total_r != pos_r) begin
              rd_en = 1'b1;
              rd_addr = IW'(total_r - 1'b1);
            end
          end else begin
            stat_nxt = ffea_pkg::ST_LOST;
            lblk_nxt = (lblk_r == '1) ? lblk_r : lblk_r + 1'b1;
            lbyt_nxt = sum_bytes[32] ? '1 : sum_bytes[31:0];
            state_nxt = S_DONE;
          end
        end
      end
      S_UP: begin
        // prev_r.len holds the insert position
        wr_en = 1'b1;
        if (pos_r == CW'(prev_r.len)) begin
          wr_data.start = addr_r;
          wr_data.len = size_r;
          total_nxt = total_r + 1'b1;
          state_nxt = S_DONE;
        end else begin
          wr_data = rd_q;
          pos_nxt = pos_r - 1'b1;
          if (pos_m1 != CW'(prev_r.len)) begin
            rd_en = 1'b1;
            rd_addr = IW'(pos_r - 2'd2);
          end
        end
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
      lblk_r <= '0;
      lbyt_r <= '0;
      rbase_r <= '0;
      rsize_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      lblk_r <= lblk_nxt;
      lbyt_r <= lbyt_nxt;
      ov_r <= ov_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ffea_pkg::CFG_REGION_BASE) rbase_r <= cfg_data;
        else rsize_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    addr_r <= addr_nxt;
    size_r <= size_nxt;
    pos_r <= pos_nxt;
    prev_r <= prev_nxt;
    stat_r <= stat_nxt;
    base_r <= base_nxt;
    if (state_r == S_DONE && (!ov_r || out_ready)) begin
      o_stat_r <= stat_r;
      o_base_r <= (cmd_r == ffea_pkg::CMD_ALLOC && stat_r == ffea_pkg::ST_OK) ? base_r : '0;
      o_cnt_r <= ffea_pkg::CNT_W'(total_r);
      o_lblk_r <= lblk_r;
      o_lbyt_r <= lbyt_r;
    end
  end

  assign out_valid = ov_r;
  assign out_status = o_stat_r;
  assign out_alloc_base = o_base_r;
  assign out_extent_count = o_cnt_r;
  assign out_lost_blocks = o_lblk_r;
  assign out_lost_bytes = o_lbyt_r;
endmodule
`default_nettype wire

// ===== rtl/ffea_checker.sv =====
// Port-level checker for the first-fit extent allocator.
// Bound to first_fit_extent_allocator_core; uses ffea_pkg codes.
`default_nettype none
module ffea_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic [31:0] out_alloc_base,
  input wire logic [31:0] out_lost_blocks
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped while stalled");
  a_base: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ffea_pkg::ST_OK |-> out_alloc_base == '0)
    else $error("nonzero base on failure");
  a_lost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ffea_pkg::ST_LOST |-> out_lost_blocks != '0)
    else $error("lost status with zero lost count");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted two items back to back");
endmodule

bind first_fit_extent_allocator_core ffea_checker u_ffea_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_alloc_base(out_alloc_base[31:0]), .out_lost_blocks(out_lost_blocks)
);
`default_nettype wire
